### hdl/dwps_pkg.sv
// Shared types, constants and command codes of the dual waveform player scheduler.
package dwps_pkg;

	localparam int WAVE_DEPTH = 1024;
	localparam int ADDR_W = $clog2(WAVE_DEPTH);
	localparam int IDX_W = 11;
	localparam int DATA_W = 32;

	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(WAVE_DEPTH);

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_LOAD_ONE = 3'd1;
	localparam logic [2:0] CMD_LOAD_TWO = 3'd2;
	localparam logic [2:0] CMD_SET_EN = 3'd3;
	localparam logic [2:0] CMD_RESTART = 3'd4;

	localparam logic [2:0] REG_UPDATE_PERIOD = 3'd0;
	localparam logic [2:0] REG_SAMPLE_COUNT = 3'd1;
	localparam logic [2:0] REG_SINGLE_PLAY = 3'd2;
	localparam logic [2:0] REG_HALF_PHASE = 3'd3;
	localparam logic [2:0] REG_FULL_PHASE = 3'd4;

	typedef struct packed {
		logic [2:0] command;
		logic [9:0] sample_index;
		logic signed [31:0] sample_value;
		logic enable_one;
		logic enable_two;
		logic stop_request;
		logic [15:0] drive_one;
		logic [15:0] drive_two;
		logic report_full;
	} item_t;

	typedef struct packed {
		logic motor_one_write;
		logic [15:0] motor_one_value;
		logic motor_two_write;
		logic [15:0] motor_two_value;
		logic demand_one_valid;
		logic signed [31:0] demand_one;
		logic demand_two_valid;
		logic signed [31:0] demand_two;
		logic stop_notice_one;
		logic stop_notice_two;
		logic enabled_one;
		logic enabled_two;
	} result_t;

	typedef struct packed {
		logic tick;
		logic set_en;
		logic en_new;
		logic stop;
		logic full;
		logic hit;
		logic restart_in;
		logic single;
		logic [15:0] period;
		logic [IDX_W-1:0] limit;
	} chan_ctl_t;

	typedef struct packed {
		logic en;
		logic en_next;
		logic write;
		logic notice;
		logic report;
		logic restart_taken;
		logic rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} chan_stat_t;

endpackage

### hdl/dwps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dwps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/dwps_chan.sv
// Per-channel sequencer: period counter, play index, enable and sample fetch request.
module dwps_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dwps_pkg::chan_ctl_t   ctl,
	output dwps_pkg::chan_stat_t  stat
);

	logic [15:0] cnt_q;
	logic [dwps_pkg::IDX_W-1:0] idx_q;
	logic en_q;

	logic [15:0] cnt_inc;
	logic adv;
	logic wrap;
	logic hit_stop;
	logic pass_stop;
	logic [dwps_pkg::IDX_W-1:0] idx0;
	logic [dwps_pkg::IDX_W-1:0] idx1;

	always_comb begin
		cnt_inc = cnt_q + 16'd1;
		adv = en_q && (cnt_inc >= ctl.period);
		idx0 = (adv && ctl.restart_in) ? '0 : idx_q;
		wrap = idx0 >= ctl.limit;
		idx1 = wrap ? '0 : idx0;
		hit_stop = en_q && ctl.hit && ctl.stop;
		pass_stop = adv && wrap && ctl.single;

		stat.en = en_q;
		stat.write = en_q ? (ctl.hit && !ctl.stop) : 1'b1;
		stat.notice = hit_stop || pass_stop;
		stat.report = adv && !ctl.full;
		stat.restart_taken = ctl.tick && adv && ctl.restart_in;
		stat.rd_en = ctl.tick && adv;
		stat.rd_addr = idx1[dwps_pkg::ADDR_W-1:0];
		if (ctl.set_en) begin
			stat.en_next = ctl.en_new;
		end else if (ctl.tick) begin
			stat.en_next = en_q && !hit_stop && !pass_stop;
		end else begin
			stat.en_next = en_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			en_q <= 1'b0;
		end else begin
			if (ctl.tick) begin
				if (en_q) begin
					cnt_q <= adv ? '0 : cnt_inc;
					idx_q <= adv ? idx1 + 1'b1 : idx_q;
				end else begin
					cnt_q <= '0;
					idx_q <= '0;
				end
			end
			if (ctl.tick || ctl.set_en) begin
				en_q <= stat.en_next;
			end
		end
	end

endmodule

### hdl/dual_waveform_player_scheduler_core.sv
// Top level of the dual waveform player scheduler: control, sample stores and result pipeline.
// Path: each item is registered in the sample read stage, then in the output register, before
// out_valid offers its result.
// Throughput: one item per cycle; the stage after the sample stores and the output register
// let a new item in while an earlier result waits, and the input stalls only when both are full.
// Reset: arst_n clears counters, indices, enables, phase, restart flag and demand holds at once
// and loads the register defaults; the two sample stores are not cleared and need no sweep.
module dual_waveform_player_scheduler_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dwps_pkg::item_t     in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output dwps_pkg::result_t   out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// Configuration registers.
	logic [15:0] update_period_q;
	logic [10:0] sample_count_q;
	logic        single_play_q;
	logic [7:0]  half_phase_q;
	logic [7:0]  full_phase_q;

	// Shared scheduling state.
	logic [7:0] phase_q;
	logic       restart_q;
	logic signed [31:0] hold_one_q;
	logic signed [31:0] hold_two_q;

	// Pipeline and output register.
	logic               s1_v_q;
	dwps_pkg::result_t  res_s1;
	logic               rd_one_s1;
	logic               rd_two_s1;
	logic               out_valid_q;
	dwps_pkg::result_t  out_q;
	dwps_pkg::result_t  res_out;

	logic accept;
	logic s1_go;
	logic is_tick;
	logic cfg_write;
	logic [dwps_pkg::IDX_W-1:0] limit;
	logic [7:0] phase_base;
	logic [8:0] phase_inc;
	logic [dwps_pkg::DATA_W-1:0] rdata_one;
	logic [dwps_pkg::DATA_W-1:0] rdata_two;
	logic load_one;
	logic load_two;
	logic index_ok;

	dwps_pkg::chan_ctl_t  ctl_one, ctl_two;
	dwps_pkg::chan_stat_t st_one, st_two;

	// Handshakes. A new item may enter whenever the read stage is empty or moves on this cycle.
	assign s1_go = !out_valid_q || out_ready;
	assign in_ready = !s1_v_q || s1_go;
	assign accept = in_valid && in_ready;
	assign is_tick = accept && (in_item.command == dwps_pkg::CMD_TICK);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// APB-style register port; writes complete in the access phase.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[4:2])
			dwps_pkg::REG_UPDATE_PERIOD: prdata = {16'd0, update_period_q};
			dwps_pkg::REG_SAMPLE_COUNT:  prdata = {21'd0, sample_count_q};
			dwps_pkg::REG_SINGLE_PLAY:   prdata = {31'd0, single_play_q};
			dwps_pkg::REG_HALF_PHASE:    prdata = {24'd0, half_phase_q};
			dwps_pkg::REG_FULL_PHASE:    prdata = {24'd0, full_phase_q};
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_period_q <= 16'd200;
			sample_count_q <= 11'd1;
			single_play_q <= 1'b0;
			half_phase_q <= 8'd25;
			full_phase_q <= 8'd50;
		end else if (cfg_write) begin
			case (paddr[4:2])
				dwps_pkg::REG_UPDATE_PERIOD: update_period_q <= pwdata[15:0];
				dwps_pkg::REG_SAMPLE_COUNT:  sample_count_q <= pwdata[10:0];
				dwps_pkg::REG_SINGLE_PLAY:   single_play_q <= pwdata[0];
				dwps_pkg::REG_HALF_PHASE:    half_phase_q <= pwdata[7:0];
				dwps_pkg::REG_FULL_PHASE:    full_phase_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// The number of samples in use never exceeds the store depth.
	assign limit = (sample_count_q > dwps_pkg::DEPTH_IDX) ? dwps_pkg::DEPTH_IDX : sample_count_q;

	// Channel control. Channel 1 gets first claim on a pending restart; channel 2 only sees
	// it when channel 1 did not take it on the same tick.
	always_comb begin
		ctl_one.tick = is_tick;
		ctl_one.set_en = accept && (in_item.command == dwps_pkg::CMD_SET_EN);
		ctl_one.en_new = in_item.enable_one;
		ctl_one.stop = in_item.stop_request;
		ctl_one.full = in_item.report_full;
		ctl_one.hit = (phase_q == half_phase_q);
		ctl_one.restart_in = restart_q;
		ctl_one.single = single_play_q;
		ctl_one.period = update_period_q;
		ctl_one.limit = limit;

		ctl_two = ctl_one;
		ctl_two.en_new = in_item.enable_two;
		ctl_two.hit = (phase_q >= full_phase_q);
		ctl_two.restart_in = restart_q && !st_one.restart_taken;
	end

	dwps_chan u_chan_one (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_one),
		.stat   (st_one)
	);

	dwps_chan u_chan_two (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_two),
		.stat   (st_two)
	);

	// Sample stores. A load writes at its own transfer; a tick reads at its transfer, so a
	// load followed by a tick on the same entry is seen in order without forwarding.
	assign index_ok = 32'(in_item.sample_index) < dwps_pkg::WAVE_DEPTH;
	assign load_one = accept && (in_item.command == dwps_pkg::CMD_LOAD_ONE) && index_ok;
	assign load_two = accept && (in_item.command == dwps_pkg::CMD_LOAD_TWO) && index_ok;

	dwps_ram #(
		.WIDTH (dwps_pkg::DATA_W),
		.DEPTH (dwps_pkg::WAVE_DEPTH)
	) u_store_one (
		.clk   (clk),
		.we    (load_one),
		.waddr (in_item.sample_index[dwps_pkg::ADDR_W-1:0]),
		.wdata (in_item.sample_value),
		.re    (st_one.rd_en),
		.raddr (st_one.rd_addr),
		.rdata (rdata_one)
	);

	dwps_ram #(
		.WIDTH (dwps_pkg::DATA_W),
		.DEPTH (dwps_pkg::WAVE_DEPTH)
	) u_store_two (
		.clk   (clk),
		.we    (load_two),
		.waddr (in_item.sample_index[dwps_pkg::ADDR_W-1:0]),
		.wdata (in_item.sample_value),
		.re    (st_two.rd_en),
		.raddr (st_two.rd_addr),
		.rdata (rdata_two)
	);

	// Phase counter. It restarts from zero on a tick where both channels are off, then counts
	// up and wraps to zero once it passes the full phase.
	assign phase_base = (!st_one.en && !st_two.en) ? 8'd0 : phase_q;
	assign phase_inc = {1'b0, phase_base} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			restart_q <= 1'b0;
		end else begin
			if (is_tick) begin
				phase_q <= (phase_inc > {1'b0, full_phase_q}) ? 8'd0 : phase_inc[7:0];
			end
			if (accept && (in_item.command == dwps_pkg::CMD_RESTART)) begin
				restart_q <= 1'b1;
			end else if (st_one.restart_taken || st_two.restart_taken) begin
				restart_q <= 1'b0;
			end
		end
	end

	// Read stage: everything but the demand values is settled at the transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.motor_one_write <= is_tick && st_one.write;
			res_s1.motor_one_value <= (is_tick && st_one.write) ? in_item.drive_one : 16'd0;
			res_s1.motor_two_write <= is_tick && st_two.write;
			res_s1.motor_two_value <= (is_tick && st_two.write) ? in_item.drive_two : 16'd0;
			res_s1.demand_one_valid <= is_tick && st_one.report;
			res_s1.demand_one <= '0;
			res_s1.demand_two_valid <= is_tick && st_two.report;
			res_s1.demand_two <= '0;
			res_s1.stop_notice_one <= is_tick && st_one.notice;
			res_s1.stop_notice_two <= is_tick && st_two.notice;
			res_s1.enabled_one <= st_one.en_next;
			res_s1.enabled_two <= st_two.en_next;
			rd_one_s1 <= st_one.rd_en;
			rd_two_s1 <= st_two.rd_en;
		end
	end

	// Output stage: a fetched sample becomes the held demand as its item leaves the read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			out_valid_q <= 1'b0;
			hold_one_q <= '0;
			hold_two_q <= '0;
		end else begin
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= s1_v_q;
			end
			if (s1_v_q && s1_go) begin
				if (rd_one_s1) begin
					hold_one_q <= rdata_one;
				end
				if (rd_two_s1) begin
					hold_two_q <= rdata_two;
				end
			end
		end
	end

	// The result leaving the read stage, with the fetched or held demands filled in.
	always_comb begin
		res_out = res_s1;
		res_out.demand_one = rd_one_s1 ? rdata_one : hold_one_q;
		res_out.demand_two = rd_two_s1 ? rdata_two : hold_two_q;
	end

	always_ff @(posedge clk) begin
		if (s1_v_q && s1_go) begin
			out_q <= res_out;
		end
	end

	// A stalled read stage must keep its fetched samples.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && !s1_go) |=> ($stable(rdata_one) && $stable(rdata_two)))
		else $error("sample read data changed under a stalled read stage");

	// A pending restart goes to at most one channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(st_one.restart_taken && st_two.restart_taken))
		else $error("restart taken by both channels");

	// A channel that stopped itself must report itself disabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.stop_notice_one && out_item.enabled_one)
			&& !(out_item.stop_notice_two && out_item.enabled_two))
		else $error("stop notice with channel still enabled");

endmodule

### verif/dual_waveform_player_scheduler_core_tb.sv
// Self-checking testbench of the dual waveform player scheduler core.
module dual_waveform_player_scheduler_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// Clock, reset and every input of the block have a known value from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	dwps_pkg::item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	dwps_pkg::result_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Idle rates of the two sides, in percent of cycles.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;

	// Results still owed by the block, oldest first.
	dwps_pkg::result_t expected_results[$];
	dwps_pkg::result_t want_res;

	// Shadow of the configuration registers, loaded with their reset values.
	logic [15:0] cfg_update_period = 16'd200;
	logic [10:0] cfg_sample_count = 11'd1;
	logic cfg_single_play = 1'b0;
	logic [7:0] cfg_half_phase = 8'd25;
	logic [7:0] cfg_full_phase = 8'd50;

	// Shadow of the player state. Index 0 is channel 1, index 1 is channel 2.
	logic [7:0] pwm_phase = '0;
	logic [15:0] tick_count[2] = '{default: '0};
	logic [dwps_pkg::IDX_W-1:0] play_idx[2] = '{default: '0};
	logic chan_en[2] = '{default: 1'b0};
	logic restart_armed = 1'b0;
	logic [dwps_pkg::DATA_W-1:0] demand_q[2] = '{default: '0};
	logic [dwps_pkg::DATA_W-1:0] wave_mem[2][dwps_pkg::WAVE_DEPTH];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dual_waveform_player_scheduler_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// One tick-counted sample advance of a channel. It returns whether a demand
	// report goes out, and raises the notice when a single pass has ended.
	function automatic logic step_sample(input int ch, input logic full, inout logic notice);
		logic [dwps_pkg::IDX_W-1:0] lim;
		lim = (cfg_sample_count < dwps_pkg::DEPTH_IDX) ? cfg_sample_count : dwps_pkg::DEPTH_IDX;
		tick_count[ch] = tick_count[ch] + 16'd1;
		if (tick_count[ch] < cfg_update_period) begin
			return 1'b0;
		end
		// A pending restart belongs to whichever channel advances first.
		if (restart_armed) begin
			play_idx[ch] = '0;
			restart_armed = 1'b0;
		end
		if (play_idx[ch] >= lim) begin
			play_idx[ch] = '0;
			if (cfg_single_play) begin
				chan_en[ch] = 1'b0;
				notice = 1'b1;
			end
		end
		// The index is below the store depth here, so it always names a store entry.
		demand_q[ch] = wave_mem[ch][play_idx[ch][dwps_pkg::ADDR_W-1:0]];
		play_idx[ch] = play_idx[ch] + 1'b1;
		tick_count[ch] = '0;
		return !full;
	endfunction

	// Applies one accepted item to the shadow state and returns the result it causes.
	function automatic dwps_pkg::result_t predict_result(input dwps_pkg::item_t it);
		dwps_pkg::result_t res;
		logic note_one;
		logic note_two;
		res = '0;
		note_one = 1'b0;
		note_two = 1'b0;
		case (it.command)
			dwps_pkg::CMD_LOAD_ONE: begin
				wave_mem[0][it.sample_index] = it.sample_value;
			end
			dwps_pkg::CMD_LOAD_TWO: begin
				wave_mem[1][it.sample_index] = it.sample_value;
			end
			dwps_pkg::CMD_SET_EN: begin
				chan_en[0] = it.enable_one;
				chan_en[1] = it.enable_two;
			end
			dwps_pkg::CMD_RESTART: begin
				restart_armed = 1'b1;
			end
			dwps_pkg::CMD_TICK: begin
				// Motor 1 is driven at the half phase while enabled and on every tick while off; a stop request there disables it.
				if (chan_en[0]) begin
					if (pwm_phase == cfg_half_phase) begin
						if (!it.stop_request) begin
							res.motor_one_write = 1'b1;
						end else begin
							chan_en[0] = 1'b0;
							note_one = 1'b1;
						end
					end
					res.demand_one_valid = step_sample(0, it.report_full, note_one);
				end else begin
					tick_count[0] = '0;
					play_idx[0] = '0;
					res.motor_one_write = 1'b1;
					// With both channels off the phase starts over.
					if (!chan_en[1]) begin
						pwm_phase = '0;
					end
				end
				// Motor 2 is driven from the full phase on while enabled, and on every tick while off.
				if (chan_en[1]) begin
					if (pwm_phase >= cfg_full_phase) begin
						if (!it.stop_request) begin
							res.motor_two_write = 1'b1;
						end else begin
							chan_en[1] = 1'b0;
							note_two = 1'b1;
						end
					end
					res.demand_two_valid = step_sample(1, it.report_full, note_two);
				end else begin
					tick_count[1] = '0;
					play_idx[1] = '0;
					res.motor_two_write = 1'b1;
				end
				if (pwm_phase >= cfg_full_phase) begin
					pwm_phase = '0;
				end else begin
					pwm_phase = pwm_phase + 8'd1;
				end
			end
			default: begin
				// The three unused codes change nothing.
			end
		endcase
		res.motor_one_value = res.motor_one_write ? it.drive_one : 16'd0;
		res.motor_two_value = res.motor_two_write ? it.drive_two : 16'd0;
		res.demand_one = demand_q[0];
		res.demand_two = demand_q[1];
		res.stop_notice_one = note_one;
		res.stop_notice_two = note_two;
		res.enabled_one = chan_en[0];
		res.enabled_two = chan_en[1];
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Result side: out_ready is redrawn every cycle from the receiver's idle rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every result transfer is held against the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no expected result waiting");
				fail_count++;
			end else begin
				want_res = expected_results.pop_front();
				check_field("motor_one_write", want_res.motor_one_write, out_item.motor_one_write);
				check_field("motor_one_value", want_res.motor_one_value, out_item.motor_one_value);
				check_field("motor_two_write", want_res.motor_two_write, out_item.motor_two_write);
				check_field("motor_two_value", want_res.motor_two_value, out_item.motor_two_value);
				check_field("demand_one_valid", want_res.demand_one_valid,
					out_item.demand_one_valid);
				check_field("demand_one", want_res.demand_one, out_item.demand_one);
				check_field("demand_two_valid", want_res.demand_two_valid,
					out_item.demand_two_valid);
				check_field("demand_two", want_res.demand_two, out_item.demand_two);
				check_field("stop_notice_one", want_res.stop_notice_one, out_item.stop_notice_one);
				check_field("stop_notice_two", want_res.stop_notice_two, out_item.stop_notice_two);
				check_field("enabled_one", want_res.enabled_one, out_item.enabled_one);
				check_field("enabled_two", want_res.enabled_two, out_item.enabled_two);
			end
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Sends one item. Valid is held high with a stable payload until the transfer, and
	// it is left high afterwards so that a back-to-back item needs no second assignment.
	task automatic send_item(input dwps_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		expected_results.push_back(predict_result(it));
	endtask

	// An item with every field random, then given the command.
	function automatic dwps_pkg::item_t make_item(input logic [2:0] cmd);
		dwps_pkg::item_t it;
		it.command = cmd;
		it.sample_index = dwps_pkg::ADDR_W'($urandom_range(dwps_pkg::WAVE_DEPTH - 1));
		it.sample_value = $urandom;
		it.enable_one = 1'($urandom_range(1));
		it.enable_two = 1'($urandom_range(1));
		it.stop_request = 1'($urandom_range(1));
		it.drive_one = 16'($urandom_range(65535));
		it.drive_two = 16'($urandom_range(65535));
		it.report_full = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic send_tick(input logic stop, input logic full);
		dwps_pkg::item_t it;
		it = make_item(dwps_pkg::CMD_TICK);
		it.stop_request = stop;
		it.report_full = full;
		send_item(it);
	endtask

	task automatic send_enables(input logic en_one, input logic en_two);
		dwps_pkg::item_t it;
		it = make_item(dwps_pkg::CMD_SET_EN);
		it.enable_one = en_one;
		it.enable_two = en_two;
		send_item(it);
	endtask

	// Lowers valid and waits until every result is in, then lets the pipeline run empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// One register write: setup phase, access phase, then the port idles before the task returns.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			dwps_pkg::REG_UPDATE_PERIOD: cfg_update_period = value[15:0];
			dwps_pkg::REG_SAMPLE_COUNT: cfg_sample_count = value[dwps_pkg::IDX_W-1:0];
			dwps_pkg::REG_SINGLE_PLAY: cfg_single_play = value[0];
			dwps_pkg::REG_HALF_PHASE: cfg_half_phase = value[7:0];
			dwps_pkg::REG_FULL_PHASE: cfg_full_phase = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Registers change only once the block has gone quiet.
	task automatic set_config(input logic [15:0] period, input logic [10:0] count,
		input logic single, input logic [7:0] half, input logic [7:0] full);
		settle();
		write_reg(dwps_pkg::REG_UPDATE_PERIOD, 32'(period));
		write_reg(dwps_pkg::REG_SAMPLE_COUNT, 32'(count));
		write_reg(dwps_pkg::REG_SINGLE_PLAY, 32'(single));
		write_reg(dwps_pkg::REG_HALF_PHASE, 32'(half));
		write_reg(dwps_pkg::REG_FULL_PHASE, 32'(full));
	endtask

	// Writes the first eighth of both sample stores. Every random phase starts with the
	// play indices at zero and has too few ticks to advance past this region, so no
	// advance reads an entry that was never loaded. The value extremes sit at the first entries.
	task automatic test_fill_stores();
		dwps_pkg::item_t it;
		for (int ch = 0; ch < 2; ch++) begin
			for (int i = 0; i < dwps_pkg::WAVE_DEPTH / 8; i++) begin
				it = make_item(ch == 0 ? dwps_pkg::CMD_LOAD_ONE : dwps_pkg::CMD_LOAD_TWO);
				it.sample_index = dwps_pkg::ADDR_W'(i);
				if (i == 0) begin
					it.sample_value = 32'sh8000_0000;
				end else if (i == 1) begin
					it.sample_value = 32'sh7fff_ffff;
				end
				send_item(it);
			end
		end
	endtask

	task automatic test_directed_cases();
		dwps_pkg::item_t it;
		// Reset settings: both channels off, so both motors are written and the phase clears.
		it = make_item(dwps_pkg::CMD_TICK);
		it.drive_one = 16'h0000;
		it.drive_two = 16'h0000;
		it.stop_request = 1'b0;
		send_item(it);
		it = make_item(dwps_pkg::CMD_TICK);
		it.drive_one = 16'hffff;
		it.drive_two = 16'hffff;
		it.stop_request = 1'b1;
		send_item(it);
		// The unused command codes.
		for (int k = 1; k <= 3; k++) begin
			send_item(make_item(dwps_pkg::CMD_RESTART + 3'(k)));
		end
		send_item(make_item(dwps_pkg::CMD_RESTART));
		send_enables(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);

		// Zero period, zero count, single play, zero phases: every tick advances both
		// channels, every advance ends a pass, and the phase stays at zero.
		set_config(16'd0, 11'd0, 1'b1, 8'd0, 8'd0);
		send_enables(1'b1, 1'b1);
		// A restart taken by channel 1 when both advance on one tick.
		send_item(make_item(dwps_pkg::CMD_RESTART));
		send_tick(1'b0, 1'b0);
		send_enables(1'b1, 1'b1);
		// A stop request on the same tick as the end of a pass.
		send_tick(1'b1, 1'b0);
		send_enables(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);

		// Largest values of every register but single play; the count lies beyond the store.
		set_config(16'hffff, 11'h7ff, 1'b0, 8'hff, 8'hff);
		send_enables(1'b1, 1'b1);
		repeat (3) send_tick(1'b0, 1'b0);

		// Full store length, advance every tick, motor 1 phase never reached.
		set_config(16'd1, 11'(dwps_pkg::WAVE_DEPTH), 1'b1, 8'hff, 8'd1);
		send_enables(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
	endtask

	// Random traffic over several register settings. Mostly ticks with enables kept
	// up, so that channels advance, wrap and stop; loads, restarts and noise between.
	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [15:0] period;
		logic [10:0] count;
		logic [7:0] full;
		logic [7:0] half;
		int sent;
		int pick;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(9))
				0: period = 16'd0;
				7: period = 16'($urandom_range(5, 40));
				8: period = 16'hffff;
				9: period = 16'($urandom_range(65535));
				default: period = 16'($urandom_range(1, 4));
			endcase
			case ($urandom_range(9))
				6: count = 11'd0;
				7: count = 11'(dwps_pkg::WAVE_DEPTH);
				8: count = 11'h7ff;
				9: count = 11'($urandom_range(2047));
				default: count = 11'($urandom_range(1, 6));
			endcase
			case ($urandom_range(7))
				0: full = 8'hff;
				1: full = 8'($urandom_range(255));
				default: full = 8'($urandom_range(12));
			endcase
			half = ($urandom_range(5) == 0) ? 8'($urandom_range(255)) :
				8'($urandom_range(int'(full)));
			set_config(period, count, 1'($urandom_range(1)), half, full);
			// A tick with both channels off brings both play indices back to zero.
			send_enables(1'b0, 1'b0);
			send_tick(1'b0, 1'b0);
			send_enables(1'b1, 1'b1);
			sent = 1;
			while (sent < per_phase) begin
				pick = $urandom_range(99);
				if (pick < 58) begin
					send_tick($urandom_range(99) < 8, $urandom_range(99) < 30);
				end else if (pick < 72) begin
					send_enables($urandom_range(99) < 80, $urandom_range(99) < 80);
				end else if (pick < 80) begin
					send_item(make_item(dwps_pkg::CMD_LOAD_ONE));
				end else if (pick < 88) begin
					send_item(make_item(dwps_pkg::CMD_LOAD_TWO));
				end else if (pick < 95) begin
					send_item(make_item(dwps_pkg::CMD_RESTART));
				end else begin
					// Ignored codes are noise and do not count toward the phase.
					send_item(make_item(dwps_pkg::CMD_RESTART + 3'($urandom_range(1, 3))));
					continue;
				end
				sent++;
			end
		end
	endtask

	// Main sequence: reset once, then each test in turn under the idle profiles.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(37, 79);
		test_fill_stores();
		test_directed_cases();
		test_random_traffic(4, 100);
		set_idling(79, 37);
		test_random_traffic(4, 100);
		set_idling(0, 0);
		test_random_traffic(4, 100);
		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("[dual_waveform_player_scheduler_core] OK");
		end else begin
			$display("[dual_waveform_player_scheduler_core] ERROR");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("[dual_waveform_player_scheduler_core] ERROR");
		$finish;
	end

endmodule
